/* rtl/indexed_list_engine_core_assert.svh */
// Assertion macros used by the indexed list engine RTL (ile_cells).
// Expects clk and arst_n in the scope of the including module.
`ifndef INDEXED_LIST_ENGINE_CORE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_CORE_ASSERT_SVH

// Check that a condition holds at every clock edge out of reset.
`define ILE_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that a trigger implies a consequence at the same edge.
`define ILE_ASSERT_SAME(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) else $error(msg);

// Check that a trigger implies a consequence at the next edge.
`define ILE_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) else $error(msg);

`endif

/* rtl/ile_pkg.sv */
// Package for the indexed list engine: sizes, action and status codes,
// and the command struct passed from the decode logic to the cell array.
package ile_pkg;

	localparam int CAPACITY = 32;
	localparam int VAL_W    = 32;
	localparam int POS_W    = 6;
	localparam int ACT_W    = 3;
	localparam int ST_W     = 2;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

	typedef enum logic [ACT_W-1:0] {
		ACT_READ      = 3'd0,
		ACT_INS_FRONT = 3'd1,
		ACT_INS_BACK  = 3'd2,
		ACT_INS_AT    = 3'd3,
		ACT_DELETE    = 3'd4
	} action_t;

	typedef enum logic [ST_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam logic [VAL_W-1:0] READ_MISS = '1;

	typedef struct packed {
		logic             ins;
		logic             del;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] value;
	} cell_cmd_t;

endpackage

/* rtl/indexed_list_engine_core.sv */
// Indexed list engine: ordered list of signed 32-bit values held in shifting
// register cells. Each item is captured in an input register; when the output
// register is empty or being drained, the request is decoded against the current
// count, the cells shift in parallel for an insert or delete, and the result lands
// in the output register. One item per cycle is sustained while the output is
// drained; a stalled output holds the item in the input register. The whole cell
// array shifts at once, along with the count. Depends on ile_pkg, ile_cells.
module indexed_list_engine_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ile_pkg::ACT_W-1:0]         action,
	input  logic [ile_pkg::POS_W-1:0]         list_position,
	input  logic signed [ile_pkg::VAL_W-1:0]  item_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [ile_pkg::VAL_W-1:0]  read_value,
	output logic [ile_pkg::ST_W-1:0]          status
);

	// Input stage: hold the accepted item until it is processed.
	logic                        valid_s1;
	logic [ile_pkg::ACT_W-1:0]   action_s1;
	logic [ile_pkg::POS_W-1:0]   position_s1;
	logic [ile_pkg::VAL_W-1:0]   value_s1;

	// Output register.
	logic                        out_valid_q;
	logic [ile_pkg::VAL_W-1:0]   read_value_q;
	logic [ile_pkg::ST_W-1:0]    status_q;

	logic advance;
	logic fire;

	// Decode signals.
	ile_pkg::cell_cmd_t          cmd;
	logic [ile_pkg::VAL_W-1:0]   rd_data;
	logic [ile_pkg::CNT_W-1:0]   count;
	logic [ile_pkg::CMP_W-1:0]   pos_ext;
	logic [ile_pkg::CMP_W-1:0]   cnt_ext;
	logic [ile_pkg::CMP_W-1:0]   ins_pos;
	logic                        is_ins;
	logic                        full;
	logic [ile_pkg::VAL_W-1:0]   rv_d;
	ile_pkg::status_t            st_d;

	// Advance when the output register is empty or being drained.
	assign advance  = !out_valid_q || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1   <= action;
			position_s1 <= list_position;
			value_s1    <= item_value;
		end
	end

	assign pos_ext = ile_pkg::CMP_W'(position_s1);
	assign cnt_ext = ile_pkg::CMP_W'(count);
	assign full    = (count == ile_pkg::CNT_W'(ile_pkg::CAPACITY));

	// Decode the request against the current count.
	always_comb begin
		rv_d    = '0;
		st_d    = ile_pkg::ST_DONE;
		is_ins  = 1'b0;
		ins_pos = '0;
		cmd     = '0;
		unique case (ile_pkg::action_t'(action_s1))
			ile_pkg::ACT_READ: begin
				if (pos_ext < cnt_ext) begin
					rv_d = rd_data;
				end else begin
					rv_d = ile_pkg::READ_MISS;
					st_d = ile_pkg::ST_RANGE;
				end
			end
			ile_pkg::ACT_INS_FRONT: begin
				is_ins  = 1'b1;
				ins_pos = '0;
			end
			ile_pkg::ACT_INS_BACK: begin
				is_ins  = 1'b1;
				ins_pos = cnt_ext;
			end
			ile_pkg::ACT_INS_AT: begin
				is_ins  = 1'b1;
				ins_pos = pos_ext;
			end
			ile_pkg::ACT_DELETE: begin
				if (pos_ext < cnt_ext) begin
					cmd.del = fire;
					cmd.idx = ile_pkg::IDX_W'(position_s1);
				end else begin
					st_d = ile_pkg::ST_RANGE;
				end
			end
			default: begin
				// Unused codes: no change, plain done.
				st_d = ile_pkg::ST_DONE;
			end
		endcase

		// Range check takes priority over the full check.
		if (is_ins) begin
			priority if (ins_pos > cnt_ext) begin
				st_d = ile_pkg::ST_RANGE;
			end else if (full) begin
				st_d = ile_pkg::ST_FULL;
			end else begin
				cmd.ins   = fire;
				cmd.idx   = ile_pkg::IDX_W'(ins_pos);
				cmd.value = value_s1;
			end
		end
	end

	ile_cells u_cells (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rd_idx  (ile_pkg::IDX_W'(position_s1)),
		.rd_data (rd_data),
		.count   (count)
	);

	// Result register: load on fire, drop valid when drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			read_value_q <= rv_d;
			status_q     <= st_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;

endmodule

/* rtl/ile_cells.sv */
// Register cell array and entry count of the indexed list engine.
// Depends on ile_pkg and indexed_list_engine_core_assert.svh.
`include "indexed_list_engine_core_assert.svh"

module ile_cells (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ile_pkg::cell_cmd_t                cmd,
	input  logic [ile_pkg::IDX_W-1:0]         rd_idx,
	output logic [ile_pkg::VAL_W-1:0]         rd_data,
	output logic [ile_pkg::CNT_W-1:0]         count
);

	logic [ile_pkg::VAL_W-1:0] cells_q [ile_pkg::CAPACITY];
	logic [ile_pkg::CNT_W-1:0] count_q;

	// Each cell looks only at its neighbors and the command: insert shifts up, delete shifts down.
	for (genvar i = 0; i < ile_pkg::CAPACITY; i++) begin : g_cell
		localparam logic [ile_pkg::IDX_W-1:0] MY_IDX = ile_pkg::IDX_W'(i);
		logic [ile_pkg::VAL_W-1:0] below;
		logic [ile_pkg::VAL_W-1:0] above;

		if (i == 0) begin : g_first
			assign below = cells_q[i];
		end else begin : g_mid
			assign below = cells_q[i-1];
		end
		if (i == ile_pkg::CAPACITY - 1) begin : g_last
			assign above = cells_q[i];
		end else begin : g_top
			assign above = cells_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.ins) begin
				if (MY_IDX == cmd.idx) begin
					cells_q[i] <= cmd.value;
				end else if (MY_IDX > cmd.idx) begin
					cells_q[i] <= below;
				end
			end else if (cmd.del && (MY_IDX >= cmd.idx)) begin
				cells_q[i] <= above;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.ins) begin
			count_q <= count_q + ile_pkg::CNT_W'(1);
		end else if (cmd.del) begin
			count_q <= count_q - ile_pkg::CNT_W'(1);
		end
	end

	assign rd_data = cells_q[rd_idx];
	assign count   = count_q;

	`ILE_ASSERT_ALWAYS(a_count_bound, count_q <= ile_pkg::CNT_W'(ile_pkg::CAPACITY), "entry count above capacity")
	`ILE_ASSERT_SAME(a_ins_room, cmd.ins, !cmd.del && (count_q < ile_pkg::CNT_W'(ile_pkg::CAPACITY)), "insert without room")
	`ILE_ASSERT_SAME(a_del_nonempty, cmd.del, (count_q != '0) && (ile_pkg::CNT_W'(cmd.idx) < count_q), "delete outside list")
	`ILE_ASSERT_NEXT(a_ins_count, cmd.ins, count_q == $past(count_q) + ile_pkg::CNT_W'(1), "insert did not grow count")
	`ILE_ASSERT_NEXT(a_del_count, cmd.del, count_q == $past(count_q) - ile_pkg::CNT_W'(1), "delete did not shrink count")

endmodule

/* tb/sv/tb_indexed_list_engine_core.sv */
// Self-checking testbench for indexed_list_engine_core: directed and random list requests
// checked against a cycle-free list predictor, with random idling on both handshakes.
// Depends on ile_pkg and the indexed_list_engine_core RTL.
module tb_indexed_list_engine_core;
	timeunit 1ns;
	timeprecision 1ps;

	import ile_pkg::*;

	// Action codes with no function; the block must answer them with a plain done.
	localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = 3'd7;
	localparam int POS_ANY_MAX = (1 << POS_W) - 1;
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE_WAIT  = 20;
	localparam int CHUNK_ITEMS  = 92;
	localparam int CHUNK_COUNT  = 20;
	localparam int REPORT_FIRST = 10;

	typedef struct {
		logic [ACT_W-1:0]        act;
		logic [POS_W-1:0]        pos;
		logic signed [VAL_W-1:0] val;
		int                      gap;
	} list_req_t;

	typedef struct {
		logic signed [VAL_W-1:0] rv;
		status_t                 st;
	} list_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [ACT_W-1:0]        action = '0;
	logic [POS_W-1:0]        list_position = '0;
	logic signed [VAL_W-1:0] item_value = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [VAL_W-1:0] read_value;
	logic [ST_W-1:0]         status;

	indexed_list_engine_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.list_position(list_position),
		.item_value   (item_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.read_value   (read_value),
		.status       (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Requests waiting to be offered, and results owed by the block in order.
	list_req_t    send_q[$];
	list_result_t result_q[$];

	// Predicted list contents and length, advanced once per accepted item.
	logic signed [VAL_W-1:0] list_cells [CAPACITY];
	int list_len = 0;

	// Running length as seen by the stimulus generator, used to aim positions.
	int gen_len = 0;

	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	int rx_wait = 0;

	int items_sent = 0;
	int results_seen = 0;
	int mismatches = 0;
	int read_hits = 0;
	int range_rejects = 0;
	int full_refusals = 0;
	int peak_len = 0;
	int cycles = 0;

	list_req_t    tx_req;
	list_result_t rx_exp;
	logic signed [VAL_W-1:0] pred_rv;
	status_t                 pred_st;

	// Shift the tail up and place the value; past-the-end wins over full.
	function automatic status_t list_insert(input int pos, input logic signed [VAL_W-1:0] val);
		if (pos > list_len)
			return ST_RANGE;
		if (list_len >= CAPACITY)
			return ST_FULL;
		for (int i = list_len; i > pos; i--)
			list_cells[i] = list_cells[i-1];
		list_cells[pos] = val;
		list_len++;
		if (list_len > peak_len)
			peak_len = list_len;
		return ST_DONE;
	endfunction

	// Apply one request to the predicted list and produce the result it owes.
	function automatic void list_apply(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
			input logic signed [VAL_W-1:0] val, output logic signed [VAL_W-1:0] rv,
			output status_t st);
		rv = '0;
		st = ST_DONE;
		case (act)
		ACT_READ: begin
			if (pos < list_len) begin
				rv = list_cells[pos];
				read_hits++;
			end else begin
				rv = READ_MISS;
				st = ST_RANGE;
			end
		end
		ACT_INS_FRONT: st = list_insert(0, val);
		ACT_INS_BACK:  st = list_insert(list_len, val);
		ACT_INS_AT:    st = list_insert(pos, val);
		ACT_DELETE: begin
			if (pos < list_len) begin
				for (int i = pos; i + 1 < list_len; i++)
					list_cells[i] = list_cells[i+1];
				list_len--;
			end else begin
				st = ST_RANGE;
			end
		end
		default: ;
		endcase
		if (st == ST_RANGE)
			range_rejects++;
		if (st == ST_FULL)
			full_refusals++;
	endfunction

	// Queue one request with its lead-in gap and track the length it leaves behind.
	task automatic queue_req(input int act, input int pos, input logic signed [VAL_W-1:0] val);
		send_q.insert(send_q.size(), list_req_t'{ACT_W'(act), POS_W'(pos), val,
			tx_calm ? 0 : $urandom_range(0, 8)});
		case (act)
		ACT_INS_FRONT, ACT_INS_BACK: if (gen_len < CAPACITY) gen_len++;
		ACT_INS_AT: if (pos <= gen_len && gen_len < CAPACITY) gen_len++;
		ACT_DELETE: if (pos < gen_len) gen_len--;
		default: ;
		endcase
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 11))
		0: return VAL_MIN;
		1: return VAL_MAX;
		2: return READ_MISS;
		3: return '0;
		default: return $urandom;
		endcase
	endfunction

	// One random request; fill_bias is the percentage of modifying requests that insert.
	task automatic queue_random(input int fill_bias);
		int roll;
		int pos;
		roll = $urandom_range(0, 99);
		if (roll < 6) begin
			// Noise: any action code, any position, spare codes included.
			queue_req($urandom_range(0, 7), $urandom_range(0, POS_ANY_MAX), $urandom);
		end else if (roll < 32) begin
			pos = (gen_len > 0 && $urandom_range(0, 4) != 0) ? $urandom_range(0, gen_len - 1)
				: $urandom_range(0, POS_ANY_MAX);
			queue_req(ACT_READ, pos, $urandom);
		end else if ($urandom_range(0, 99) < fill_bias) begin
			pos = ($urandom_range(0, 6) != 0) ? $urandom_range(0, gen_len)
				: $urandom_range(0, POS_ANY_MAX);
			case ($urandom_range(0, 2))
			0: queue_req(ACT_INS_FRONT, $urandom_range(0, POS_ANY_MAX), pick_value());
			1: queue_req(ACT_INS_BACK, $urandom_range(0, POS_ANY_MAX), pick_value());
			default: queue_req(ACT_INS_AT, pos, pick_value());
			endcase
		end else begin
			pos = (gen_len > 0 && $urandom_range(0, 6) != 0) ? $urandom_range(0, gen_len - 1)
				: $urandom_range(0, POS_ANY_MAX);
			queue_req(ACT_DELETE, pos, $urandom);
		end
	endtask

	// Hold until every queued request is accepted and every owed result has come back.
	task automatic drain();
		while (send_q.size() != 0 || in_valid || result_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic note_mismatch(input string what);
		mismatches++;
		if (mismatches <= REPORT_FIRST)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// Driver: predict each item as it is accepted, then offer the next one
	// once its drawn gap has run out. Payload holds while valid waits on ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= '0;
			list_position <= '0;
			item_value <= '0;
		end else begin
			if (in_valid && in_ready) begin
				list_apply(action, list_position, item_value, pred_rv, pred_st);
				result_q.insert(result_q.size(), list_result_t'{pred_rv, pred_st});
				items_sent++;
			end
			if (!in_valid || in_ready) begin
				if (send_q.size() == 0) begin
					in_valid <= 1'b0;
				end else if (send_q[0].gap > 0) begin
					send_q[0].gap--;
					in_valid <= 1'b0;
				end else begin
					tx_req = send_q.pop_front();
					in_valid <= 1'b1;
					action <= tx_req.act;
					list_position <= tx_req.pos;
					item_value <= tx_req.val;
				end
			end
		end
	end

	// Monitor: check each accepted result against the oldest prediction, then
	// draw how long to stall the next one. The stall only counts down while a
	// result is actually being offered.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b1;
			rx_wait = 0;
		end else if (out_valid && out_ready) begin
			if (result_q.size() == 0) begin
				note_mismatch($sformatf("result with nothing owed: read_value %0d status %0d",
					read_value, status));
			end else begin
				rx_exp = result_q.pop_front();
				if (read_value !== rx_exp.rv || status !== rx_exp.st)
					note_mismatch($sformatf(
						"result %0d: expected read_value %0d status %0d, got %0d status %0d",
						results_seen, rx_exp.rv, rx_exp.st, read_value, status));
			end
			results_seen++;
			if (results_seen % 64 == 0)
				rx_calm = ($urandom_range(0, 3) == 0);
			rx_wait = rx_calm ? 0 : $urandom_range(0, 8);
			out_ready <= (rx_wait == 0);
		end else if (out_valid && !out_ready) begin
			if (rx_wait <= 1)
				out_ready <= 1'b1;
			rx_wait--;
		end
	end

	// Watchdog: give up well past the slowest correct run.
	always @(posedge clk) begin
		if (arst_n) begin
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d results still owed", cycles,
					result_q.size());
				$display("FAIL indexed_list_engine_core");
				$finish;
			end
		end
	end

	initial begin
		int fill_bias [8];
		fill_bias = '{90, 20, 60, 95, 10, 50, 85, 5};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty-list misses, edge values, a stored -1 next to a miss,
		// middle insert and delete, append at the count, far positions, spare codes.
		queue_req(ACT_READ, 0, '0);
		queue_req(ACT_DELETE, 0, '0);
		queue_req(ACT_INS_AT, 1, VAL_MAX);
		queue_req(ACT_INS_AT, 0, VAL_MAX);
		queue_req(ACT_INS_FRONT, POS_ANY_MAX, READ_MISS);
		queue_req(ACT_INS_BACK, POS_ANY_MAX, VAL_MIN);
		queue_req(ACT_INS_AT, 1, '0);
		queue_req(ACT_READ, 0, '0);
		queue_req(ACT_READ, 1, '0);
		queue_req(ACT_READ, 3, '0);
		queue_req(ACT_READ, 4, '0);
		queue_req(ACT_READ, POS_ANY_MAX, READ_MISS);
		queue_req(ACT_DELETE, 1, '0);
		queue_req(ACT_DELETE, 3, '0);
		queue_req(ACT_INS_AT, 3, 32'h5a5a_a5a5);
		queue_req(ACT_INS_AT, POS_ANY_MAX, 32'h0f0f_f0f0);
		queue_req(ACT_SPARE_FIRST, POS_ANY_MAX, READ_MISS);
		queue_req(ACT_SPARE_FIRST + 1, 0, VAL_MIN);
		queue_req(ACT_SPARE_LAST, CAPACITY, VAL_MAX);
		queue_req(ACT_DELETE, 0, '0);
		queue_req(ACT_READ, 2, '0);
		queue_req(ACT_DELETE, 2, '0);

		// Let the directed part finish completely before random traffic starts.
		drain();

		// Random: chunks vary the insert bias between filling and emptying the list so
		// full refusals, deep shifts and empty misses all come up repeatedly.
		for (int c = 0; c < CHUNK_COUNT; c++) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < CHUNK_ITEMS; k++)
				queue_random(fill_bias[c % 8]);
			if (c == CHUNK_COUNT / 2)
				drain();
		end

		drain();
		repeat (SETTLE_WAIT) @(posedge clk);

		$display("Covered %0d requests and %0d results; %0d read hits, %0d range rejects,",
			items_sent, results_seen, read_hits, range_rejects);
		$display("%0d refused on a full list, longest list %0d, %0d mismatches.",
			full_refusals, peak_len, mismatches);
		if (mismatches == 0 && result_q.size() == 0)
			$display("PASS indexed_list_engine_core");
		else
			$display("FAIL indexed_list_engine_core");
		$finish;
	end

endmodule
